// ----- rtl/lfpd_pkg.sv -----
// lfpd_pkg: shared constants and types of the length framed packet deframer
// store geometry, event and register codes, store access struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lfpd_pkg;

   localparam int STORE_DEPTH = 64;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int POS_W       = $clog2(STORE_DEPTH + 1);
   localparam int CSR_IDX_W   = 8;

   localparam logic [7:0] START_CODE_RESET = 8'h01;
   localparam logic [7:0] END_CODE_RESET   = 8'h04;

   localparam logic [CSR_IDX_W-1:0] CSR_START_CODE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_END_CODE   = CSR_IDX_W'(1);

   typedef enum logic [2:0] {
      EV_OK       = 3'd0,
      EV_STRAY    = 3'd1,
      EV_PAYLOAD  = 3'd2,
      EV_EMPTY    = 3'd3,
      EV_BADEND   = 3'd4,
      EV_OVERFLOW = 3'd5
   } lfpd_event_type;

   typedef enum logic [7:0] {
      PH_WAIT    = 8'b0000_0001,
      PH_RES0    = 8'b0000_0010,
      PH_RES1    = 8'b0000_0100,
      PH_LEN     = 8'b0000_1000,
      PH_DATA    = 8'b0001_0000,
      PH_END     = 8'b0010_0000,
      PH_REL_RD  = 8'b0100_0000,
      PH_REL_OUT = 8'b1000_0000
   } lfpd_phase_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } lfpd_store_req_type;

endpackage

`default_nettype wire

// ----- rtl/length_framed_packet_deframer_core.sv -----
// length_framed_packet_deframer_core: frame parser, release sequencer, result register
// a status result is registered when its request is taken; a request is taken each cycle
// while the result register drains; a release of n payload bytes does one store read and
// one result load per byte, with requests stalled meanwhile
// reset: parser waits for start code, codes back to 1 and 4, result register empty,
// payload store not cleared; depends on lfpd_pkg and lfpd_payload_store
`timescale 1ns / 1ps
`default_nettype none

module length_framed_packet_deframer_core (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire  [7:0]                     req_rx_byte,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic [2:0]                     rsp_event_res,
   output logic [7:0]                     rsp_payload_byte,
   output logic                           rsp_last_byte,
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire  [lfpd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [7:0]                     csr_wdata
);
   import lfpd_pkg::*;

   lfpd_phase_type     phase_ff, phase_in;
   logic [7:0]         remain_ff, remain_in;
   logic [POS_W-1:0]   wpos_ff, wpos_in;
   logic [POS_W-1:0]   rel_idx_ff, rel_idx_in;
   logic [7:0]         start_code_ff, end_code_ff;

   logic               out_valid_ff, out_valid_in;
   lfpd_event_type     out_event_ff, out_event_in;
   logic [7:0]         out_byte_ff, out_byte_in;
   logic               out_last_ff, out_last_in;

   lfpd_store_req_type store_req;
   logic [7:0]         rd_data;
   logic               releasing;
   logic               out_free;
   logic               req_fire;
   logic [POS_W-1:0]   wpos_inc;
   logic [7:0]         remain_dec;

   lfpd_payload_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_data   (rd_data)
   );

   assign releasing = phase_ff inside {PH_REL_RD, PH_REL_OUT};
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = releasing || !out_free;
   assign req_fire  = req_valid && !req_stall;
   assign wpos_inc  = wpos_ff + POS_W'(1);
   assign remain_dec = remain_ff - 8'd1;
   assign csr_ready = 1'b1;

   always_comb begin
      phase_in     = phase_ff;
      remain_in    = remain_ff;
      wpos_in      = wpos_ff;
      rel_idx_in   = rel_idx_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_event_in = out_event_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      store_req.wr_en   = 1'b0;
      store_req.wr_addr = wpos_ff[ADDR_W-1:0];
      store_req.wr_data = req_rx_byte;
      store_req.rd_en   = 1'b0;
      store_req.rd_addr = rel_idx_ff[ADDR_W-1:0];

      if (req_fire) begin
         out_valid_in = 1'b1;
         out_event_in = EV_OK;
         out_byte_in  = 8'd0;
         out_last_in  = 1'b0;
         case (phase_ff)
            PH_RES0: phase_in = PH_RES1;
            PH_RES1: phase_in = PH_LEN;
            PH_LEN: begin
               remain_in = req_rx_byte;
               phase_in  = (req_rx_byte != 8'd0) ? PH_DATA : PH_END;
            end
            PH_DATA: begin
               store_req.wr_en = 1'b1;
               wpos_in   = wpos_inc;
               remain_in = remain_dec;
               if (remain_dec == 8'd0) begin
                  phase_in = PH_END;
               end
               if (wpos_inc >= POS_W'(STORE_DEPTH)) begin
                  phase_in     = PH_WAIT;
                  remain_in    = 8'd0;
                  wpos_in      = '0;
                  out_event_in = EV_OVERFLOW;
               end
            end
            PH_END: begin
               phase_in  = PH_WAIT;
               remain_in = 8'd0;
               if (req_rx_byte != end_code_ff) begin
                  wpos_in      = '0;
                  out_event_in = EV_BADEND;
               end else if (wpos_ff == '0) begin
                  out_event_in = EV_EMPTY;
               end else begin
                  phase_in     = PH_REL_RD;
                  rel_idx_in   = '0;
                  out_valid_in = 1'b0;
               end
            end
            default: begin
               phase_in = PH_WAIT;
               if (req_rx_byte == start_code_ff) begin
                  phase_in = PH_RES0;
               end else begin
                  out_event_in = EV_STRAY;
               end
            end
         endcase
      end else if (phase_ff == PH_REL_RD) begin
         store_req.rd_en = 1'b1;
         phase_in = PH_REL_OUT;
      end else if ((phase_ff == PH_REL_OUT) && out_free) begin
         out_valid_in = 1'b1;
         out_event_in = EV_PAYLOAD;
         out_byte_in  = rd_data;
         out_last_in  = (rel_idx_ff + POS_W'(1)) == wpos_ff;
         rel_idx_in   = rel_idx_ff + POS_W'(1);
         if (out_last_in) begin
            phase_in = PH_WAIT;
            wpos_in  = '0;
         end else begin
            phase_in = PH_REL_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_WAIT;
         remain_ff     <= 8'd0;
         wpos_ff       <= '0;
         rel_idx_ff    <= '0;
         out_valid_ff  <= 1'b0;
         start_code_ff <= START_CODE_RESET;
         end_code_ff   <= END_CODE_RESET;
      end else begin
         phase_ff     <= phase_in;
         remain_ff    <= remain_in;
         wpos_ff      <= wpos_in;
         rel_idx_ff   <= rel_idx_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_START_CODE) begin
               start_code_ff <= csr_wdata;
            end else if (csr_index == CSR_END_CODE) begin
               end_code_ff <= csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      out_event_ff <= out_event_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_res    = out_event_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_last_byte    = out_last_ff;

`ifndef SYNTHESIS
   a_no_request_in_release: assert property (@(posedge clock) disable iff (reset)
      releasing |-> req_stall)
      else $error("request accepted during release");

   a_wpos_in_range: assert property (@(posedge clock) disable iff (reset)
      wpos_ff < POS_W'(STORE_DEPTH))
      else $error("write position reached store depth");

   a_release_idx_valid: assert property (@(posedge clock) disable iff (reset)
      releasing |-> (rel_idx_ff < wpos_ff))
      else $error("release index beyond stored payload");

   a_last_is_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_byte) |-> (rsp_event_res == EV_PAYLOAD))
      else $error("last flag on a status result");

   a_read_before_out: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_REL_OUT) |-> ($past(phase_ff) == PH_REL_RD
                                    || $past(phase_ff) == PH_REL_OUT))
      else $error("release output without store read");
`endif

endmodule

`default_nettype wire

// ----- rtl/lfpd_payload_store.sv -----
// lfpd_payload_store: payload byte memory, one write and one read port
// read data registered; depends on lfpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module lfpd_payload_store (
   input  wire                            clock,
   input  wire lfpd_pkg::lfpd_store_req_type store_req,
   output logic [7:0]                     rd_data
);
   import lfpd_pkg::*;

   logic [7:0] store_ff [STORE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         store_ff[store_req.wr_addr] <= store_req.wr_data;
      end
      if (store_req.rd_en) begin
         rd_data_ff <= store_ff[store_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// tb_top: self-checking testbench of length_framed_packet_deframer_core
// a directed table and random framed traffic, results checked by table or in-bench deframer
// depends on lfpd_pkg and the deframer core
`timescale 1ns / 1ps

module tb_top;
   import lfpd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 300000;

   typedef struct packed {
      lfpd_event_type ev;
      logic [7:0]     data;
      logic           last;
   } deframe_result_type;

   typedef struct packed {
      logic [7:0]     rx;
      logic           known;
      lfpd_event_type ev;
   } stim_row_type;

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic [7:0]           req_rx_byte = 8'h00;
   logic                 rsp_stall = 1'b0;
   logic                 csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0]           csr_wdata = 8'h00;
   logic                 req_stall;
   logic                 rsp_valid;
   logic [2:0]           rsp_event_res;
   logic [7:0]           rsp_payload_byte;
   logic                 rsp_last_byte;
   logic                 csr_ready;

   bit                   steady = 1'b0;
   int unsigned          cycle_count = 0;
   int unsigned          mismatch_count = 0;
   int unsigned          requests_sent = 0;

   // deframer state as seen by the bench
   logic [7:0]           start_code_cfg = START_CODE_RESET;
   logic [7:0]           end_code_cfg = END_CODE_RESET;
   lfpd_phase_type       parse_phase = PH_WAIT;
   logic [7:0]           bytes_left = 8'h00;
   int unsigned          fill_count = 0;
   logic [7:0]           frame_bytes [STORE_DEPTH];

   deframe_result_type   step_results [$];
   deframe_result_type   pending_results [$];

   stim_row_type directed_rows [26] = '{
      '{8'h00, 1'b1, EV_STRAY},
      '{8'hFF, 1'b1, EV_STRAY},
      '{8'h01, 1'b1, EV_OK},
      '{8'hAA, 1'b0, EV_OK},
      '{8'h55, 1'b0, EV_OK},
      '{8'h00, 1'b0, EV_OK},
      '{8'h04, 1'b1, EV_EMPTY},
      '{8'h01, 1'b0, EV_OK},
      '{8'h00, 1'b0, EV_OK},
      '{8'hFF, 1'b0, EV_OK},
      '{8'h02, 1'b0, EV_OK},
      '{8'h00, 1'b0, EV_OK},
      '{8'hFF, 1'b0, EV_OK},
      '{8'h04, 1'b0, EV_OK},
      '{8'h01, 1'b0, EV_OK},
      '{8'h00, 1'b0, EV_OK},
      '{8'h00, 1'b0, EV_OK},
      '{8'h00, 1'b0, EV_OK},
      '{8'h77, 1'b1, EV_BADEND},
      '{8'h04, 1'b1, EV_STRAY},
      '{8'h01, 1'b0, EV_OK},
      '{8'h12, 1'b0, EV_OK},
      '{8'h34, 1'b0, EV_OK},
      '{8'h01, 1'b0, EV_OK},
      '{8'h81, 1'b0, EV_OK},
      '{8'h04, 1'b0, EV_OK}
   };

   length_framed_packet_deframer_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_res    (rsp_event_res),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last_byte    (rsp_last_byte),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void drop_frame();
      parse_phase = PH_WAIT;
      bytes_left  = 8'h00;
      fill_count  = 0;
   endfunction

   function automatic void deframe_byte(input logic [7:0] b);
      deframe_result_type r;
      r = '{EV_OK, 8'h00, 1'b0};
      step_results.delete();
      case (parse_phase)
         PH_RES0: parse_phase = PH_RES1;
         PH_RES1: parse_phase = PH_LEN;
         PH_LEN: begin
            bytes_left = b;
            if (b != 8'h00) parse_phase = PH_DATA;
            else parse_phase = PH_END;
         end
         PH_DATA: begin
            frame_bytes[fill_count] = b;
            fill_count++;
            bytes_left--;
            if (bytes_left == 8'h00) parse_phase = PH_END;
            if (fill_count >= STORE_DEPTH) begin
               drop_frame();
               r.ev = EV_OVERFLOW;
            end
         end
         PH_END: begin
            if (b != end_code_cfg) begin
               drop_frame();
               r.ev = EV_BADEND;
            end else if (fill_count == 0) begin
               drop_frame();
               r.ev = EV_EMPTY;
            end else begin
               for (int i = 0; i < fill_count; i++)
                  step_results.push_back('{EV_PAYLOAD, frame_bytes[i], i + 1 == fill_count});
               drop_frame();
               return;
            end
         end
         default: begin
            parse_phase = PH_WAIT;
            if (b == start_code_cfg) parse_phase = PH_RES0;
            else r.ev = EV_STRAY;
         end
      endcase
      step_results.push_back(r);
   endfunction

   task automatic send_request(input logic [7:0] b, input logic known, input lfpd_event_type ev);
      while (!steady && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      deframe_byte(b);
      if (known) pending_results.push_back('{ev, 8'h00, 1'b0});
      else foreach (step_results[k]) pending_results.push_back(step_results[k]);
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_request(b, 1'b0, EV_OK);
   endtask

   task automatic send_frame(input int len, input bit good_end);
      int         n;
      logic [7:0] end_byte;
      send_byte(start_code_cfg);
      send_byte(8'($urandom_range(255)));
      send_byte(8'($urandom_range(255)));
      send_byte(8'(len));
      n = (len >= STORE_DEPTH) ? STORE_DEPTH : len;
      repeat (n) send_byte(8'($urandom_range(255)));
      if (len < STORE_DEPTH) begin
         end_byte = end_code_cfg;
         if (!good_end)
            do end_byte = 8'($urandom_range(255)); while (end_byte == end_code_cfg);
         send_byte(end_byte);
      end
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_START_CODE) start_code_cfg = data;
      else if (idx == CSR_END_CODE) end_code_cfg = data;
   endtask

   task automatic set_codes(input logic [7:0] s, input logic [7:0] e);
      req_valid <= 1'b0;
      wait_drained();
      write_register(CSR_START_CODE, s);
      write_register(CSR_END_CODE, e);
      // unmapped index, must be ignored
      write_register(CSR_IDX_W'($urandom_range(2, 255)), 8'($urandom_range(255)));
      csr_valid <= 1'b0;
   endtask

   task automatic run_traffic(input int unsigned quota);
      int unsigned first;
      int unsigned pick;
      int          len;
      first = requests_sent;
      while (requests_sent - first < quota) begin
         pick = $urandom_range(99);
         len  = ($urandom_range(11) == 0) ? $urandom_range(10, 63) : $urandom_range(0, 9);
         if (pick < 70) send_frame(len, 1'b1);
         else if (pick < 85) send_frame(len, 1'b0);
         else repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end
   endtask

   always @(posedge clock) rsp_stall <= !steady && ($urandom_range(99) < 24);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result event %0d payload %0h last %0b", $time,
                     rsp_event_res, rsp_payload_byte, rsp_last_byte);
            mismatch_count++;
         end else begin
            if (rsp_event_res !== pending_results[0].ev) begin
               $display("%0t event_res expected %0d got %0d", $time,
                        pending_results[0].ev, rsp_event_res);
               mismatch_count++;
            end
            if (rsp_payload_byte !== pending_results[0].data) begin
               $display("%0t payload_byte expected %0h got %0h", $time,
                        pending_results[0].data, rsp_payload_byte);
               mismatch_count++;
            end
            if (rsp_last_byte !== pending_results[0].last) begin
               $display("%0t last_byte expected %0b got %0b", $time,
                        pending_results[0].last, rsp_last_byte);
               mismatch_count++;
            end
            void'(pending_results.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** length_framed_packet_deframer_core: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[k])
         send_request(directed_rows[k].rx, directed_rows[k].known, directed_rows[k].ev);

      // reset codes, then overflow with no idling on either side
      run_traffic(14);
      steady = 1'b1;
      send_frame(64, 1'b1);
      send_frame(1, 1'b1);
      steady = 1'b0;

      set_codes(8'h00, 8'hFF);
      steady = 1'b1;
      run_traffic(14);
      steady = 1'b0;

      set_codes(8'hFF, 8'h00);
      run_traffic(12);

      set_codes(8'($urandom_range(255)), 8'($urandom_range(255)));
      run_traffic(12);

      // same byte opens and closes a frame
      set_codes(8'h7E, 8'h7E);
      run_traffic(10);

      req_valid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("** length_framed_packet_deframer_core: PASSED **");
      else
         $display("** length_framed_packet_deframer_core: FAILED **");
      $finish;
   end

endmodule
